// File: sv/poqe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poqe_pkg
// shared constants and types of the polygon outline quad expander
// ----------------------------------------------------------------------------
package poqe_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF   = 8;
   localparam int THICK_WIDTH     = 16;
   localparam logic [THICK_WIDTH-1:0] THICK_RESET = 16'd256;
   localparam int CSR_ADDR_WIDTH  = 2;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_THICKNESS = 2'd0;

   // commands from controller to datapath
   typedef struct packed {
      logic load_in;     // take input vertex
      logic edge_start;  // latch endpoints, compute differences
      logic edge_close;  // 0: prev->cur, 1: cur->first
      logic sqrt_start;
      logic div_start;
      logic div_half;    // 0: full, 1: half
      logic offs_calc;   // form the four corners
      logic commit;      // update prev
   } poqe_cmd_type;

   typedef struct packed {
      logic zero_len;
      logic close_zero;  // current vertex equals first vertex
      logic sqrt_done;
      logic div_done;
   } poqe_sts_type;

endpackage

// File: sv/poqe_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poqe_datapath
// edge differences, iterative square root, shared serial divider, corners
// ----------------------------------------------------------------------------
module poqe_datapath
   import poqe_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  poqe_cmd_type                  cmd,
   output poqe_sts_type                  sts,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   input  logic [THICK_WIDTH-1:0]        thickness,
   input  logic [2:0]                    sel,
   output logic signed [COORD_WIDTH-1:0] pt_x,
   output logic signed [COORD_WIDTH-1:0] pt_y
);

   localparam int DW = COORD_WIDTH + 1;           // difference width
   localparam int MW = 31;                        // magnitude after prescale
   localparam int SW = 2 * MW + 1;                // sum of squares
   localparam int RW = MW + 1;                    // root width
   localparam int PW = MW + THICK_WIDTH;          // product width
   localparam int QW = PW;                        // quotient width
   localparam int EW = ((COORD_WIDTH > THICK_WIDTH) ? COORD_WIDTH : THICK_WIDTH) + 3;
   localparam int SHW = $clog2(DW + 1);
   localparam int SCW = $clog2(RW + 1);
   localparam int DCW = $clog2(PW + 2);

   logic signed [COORD_WIDTH-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [COORD_WIDTH-1:0] cur_x_ff, cur_y_ff;
   logic signed [COORD_WIDTH-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [DW-1:0]  mx_ff, my_ff;
   logic           nx_ff, ny_ff;
   logic [MW-1:0]  sx_ff, sy_ff;
   logic [SW-1:0]  rem_ff;
   logic [SW-1:0]  root_ff;
   logic [SW-1:0]  bit_ff;
   logic [SCW-1:0] scnt_ff;
   logic           sq_phase_ff;  // 0: mult, 1: iterate
   logic           sbusy_ff;
   logic [PW-1:0]  px_ff, py_ff;
   logic [PW+1:0]  nrx_ff, nry_ff; // numerators
   logic [QW-1:0]  qx_ff, qy_ff;
   logic [PW+1:0]  rx_ff, ry_ff;
   logic [RW:0]    den_ff;
   logic [DCW-1:0] dcnt_ff;
   logic           dbusy_ff;
   logic signed [EW-1:0] vx_ff, vy_ff;
   logic signed [EW-1:0] a0x_ff, a0y_ff, b0x_ff, b0y_ff, nvx_ff, nvy_ff;

   logic signed [DW-1:0] dx, dy;
   logic [SHW-1:0] shamt;
   logic [DW-1:0]  mxs, mys;

   always_comb begin
      logic signed [COORD_WIDTH-1:0] a_x, a_y, b_x, b_y;
      a_x = cmd.edge_close ? cur_x_ff : prev_x_ff;
      a_y = cmd.edge_close ? cur_y_ff : prev_y_ff;
      b_x = cmd.edge_close ? first_x_ff : cur_x_ff;
      b_y = cmd.edge_close ? first_y_ff : cur_y_ff;
      dx = DW'(b_x) - DW'(a_x);
      dy = DW'(b_y) - DW'(a_y);
   end

   // prescale so that both magnitudes fit below 2^31
   always_comb begin
      logic [DW-1:0] orv;
      orv = mx_ff | my_ff;
      shamt = '0;
      for (int i = MW; i < DW; i++) begin
         if (orv[i]) shamt = SHW'(i - MW + 1);
      end
      mxs = mx_ff >> shamt;
      mys = my_ff >> shamt;
   end

   assign sts.zero_len = (mx_ff == '0) && (my_ff == '0);
   assign sts.close_zero = (cur_x_ff == first_x_ff) && (cur_y_ff == first_y_ff);
   assign sts.sqrt_done = !sbusy_ff;
   assign sts.div_done = !dbusy_ff;

   logic [SW-1:0] trial;
   assign trial = root_ff + bit_ff;

   logic [PW+1:0] trx, try_;
   assign trx  = {rx_ff[PW:0], nrx_ff[PW+1]};
   assign try_ = {ry_ff[PW:0], nry_ff[PW+1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff <= '0; first_y_ff <= '0;
         prev_x_ff <= '0; prev_y_ff <= '0;
         sbusy_ff <= 1'b0;
         dbusy_ff <= 1'b0;
      end else begin
         if (cmd.load_in) begin
            cur_x_ff <= in_x;
            cur_y_ff <= in_y;
         end
         if (cmd.commit) begin
            prev_x_ff <= cur_x_ff;
            prev_y_ff <= cur_y_ff;
         end
         if (cmd.load_in && sel[0]) begin
            first_x_ff <= in_x;
            first_y_ff <= in_y;
         end
         if (cmd.edge_start) begin
            ax_ff <= cmd.edge_close ? cur_x_ff : prev_x_ff;
            ay_ff <= cmd.edge_close ? cur_y_ff : prev_y_ff;
            bx_ff <= cmd.edge_close ? first_x_ff : cur_x_ff;
            by_ff <= cmd.edge_close ? first_y_ff : cur_y_ff;
            nx_ff <= dx[DW-1];
            ny_ff <= dy[DW-1];
            mx_ff <= dx[DW-1] ? -dx : dx;
            my_ff <= dy[DW-1] ? -dy : dy;
         end
         // square root: a multiply step, then one bit pair per cycle
         if (cmd.sqrt_start) begin
            sx_ff <= MW'(mxs);
            sy_ff <= MW'(mys);
            sbusy_ff <= 1'b1;
            sq_phase_ff <= 1'b0;
         end else if (sbusy_ff && !sq_phase_ff) begin
            rem_ff <= SW'(sx_ff) * SW'(sx_ff) + SW'(sy_ff) * SW'(sy_ff);
            root_ff <= '0;
            bit_ff <= SW'(1) << (2 * MW);
            scnt_ff <= SCW'(MW + 1);
            sq_phase_ff <= 1'b1;
            px_ff <= PW'(sx_ff) * PW'(thickness);
            py_ff <= PW'(sy_ff) * PW'(thickness);
         end else if (sbusy_ff) begin
            if (rem_ff >= trial) begin
               rem_ff <= rem_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            scnt_ff <= scnt_ff - 1'b1;
            if (scnt_ff == SCW'(1)) sbusy_ff <= 1'b0;
         end
         // restoring division, one quotient bit per cycle, both axes together
         if (cmd.div_start) begin
            logic [RW:0] d;
            d = (root_ff == '0) ? (RW+1)'(1) : {1'b0, RW'(root_ff)};
            if (cmd.div_half) d = d << 1;
            den_ff <= d;
            nrx_ff <= ((PW+2)'(px_ff) + (PW+2)'(d >> 1)) << 0;
            nry_ff <= ((PW+2)'(py_ff) + (PW+2)'(d >> 1));
            rx_ff <= '0; ry_ff <= '0;
            dcnt_ff <= DCW'(PW + 2);
            dbusy_ff <= 1'b1;
         end else if (dbusy_ff) begin
            nrx_ff <= nrx_ff << 1;
            nry_ff <= nry_ff << 1;
            if (trx >= (PW+2)'(den_ff)) begin
               rx_ff <= trx - (PW+2)'(den_ff);
               qx_ff <= {qx_ff[QW-2:0], 1'b1};
            end else begin
               rx_ff <= trx;
               qx_ff <= {qx_ff[QW-2:0], 1'b0};
            end
            if (try_ >= (PW+2)'(den_ff)) begin
               ry_ff <= try_ - (PW+2)'(den_ff);
               qy_ff <= {qy_ff[QW-2:0], 1'b1};
            end else begin
               ry_ff <= try_;
               qy_ff <= {qy_ff[QW-2:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff - 1'b1;
            if (dcnt_ff == DCW'(1)) dbusy_ff <= 1'b0;
         end
         if (cmd.offs_calc) begin
            logic signed [EW-1:0] hxs, hys;
            hxs = nx_ff ? -EW'(qx_ff) : EW'(qx_ff);
            hys = ny_ff ? -EW'(qy_ff) : EW'(qy_ff);
            a0x_ff <= EW'(ax_ff) - hxs;
            a0y_ff <= EW'(ay_ff) - hys;
            b0x_ff <= EW'(bx_ff) + hxs;
            b0y_ff <= EW'(by_ff) + hys;
            nvx_ff <= vy_ff;
            nvy_ff <= vx_ff;
         end
      end
   end

   // keep full-length result when the half divide starts
   always_ff @(posedge clock) begin
      if (cmd.div_start && cmd.div_half) begin
         vx_ff <= nx_ff ? -EW'(qx_ff) : EW'(qx_ff);
         vy_ff <= ny_ff ? -EW'(qy_ff) : EW'(qy_ff);
      end
   end

   // corner selection and saturation
   always_comb begin
      logic signed [EW-1:0] ex, ey, hi, lo;
      logic use_b, plus_n;
      use_b  = (sel == 3'd1) || (sel == 3'd2) || (sel == 3'd4);
      plus_n = (sel == 3'd1) || (sel == 3'd4) || (sel == 3'd5);
      ex = (use_b ? b0x_ff : a0x_ff) + (plus_n ? -nvx_ff : nvx_ff);
      ey = (use_b ? b0y_ff : a0y_ff) + (plus_n ? nvy_ff : -nvy_ff);
      hi = EW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
      lo = -hi - EW'(1);
      if (ex > hi) ex = hi;
      if (ex < lo) ex = lo;
      if (ey > hi) ey = hi;
      if (ey < lo) ey = lo;
      pt_x = ex[COORD_WIDTH-1:0];
      pt_y = ey[COORD_WIDTH-1:0];
   end

endmodule

// File: sv/poqe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poqe_ctrl
// sequencer for vertex intake, edge computation and result transfers
// ----------------------------------------------------------------------------
module poqe_ctrl
   import poqe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic         in_closes,
   output logic         out_valid,
   input  logic         out_ready,
   output logic         out_last,
   output logic [2:0]   sel,
   output poqe_cmd_type cmd,
   input  poqe_sts_type sts
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_EDGE, ST_LEN, ST_SQRT, ST_DIVF, ST_DIVH, ST_CORN, ST_EMIT, ST_NEXT
   } state_type;

   state_type state_ff;
   logic      have_prev_ff, closes_ff, closing_ff, pend_ff;
   logic [2:0] k_ff;
   logic      last_edge;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_EMIT);
   assign last_edge = closing_ff || !closes_ff || sts.close_zero;
   assign out_last  = (k_ff == 3'd5) && last_edge;

   always_comb begin
      cmd = '0;
      cmd.edge_close = closing_ff;
      sel = k_ff;
      if (state_ff == ST_IDLE) begin
         cmd.load_in = in_valid;
         sel = {2'b00, !have_prev_ff};
      end
      cmd.edge_start = (state_ff == ST_EDGE);
      cmd.sqrt_start = (state_ff == ST_LEN) && !sts.zero_len;
      cmd.div_start  = ((state_ff == ST_SQRT) && sts.sqrt_done && !pend_ff) ||
                       ((state_ff == ST_DIVF) && sts.div_done && !pend_ff);
      cmd.div_half   = (state_ff == ST_DIVF);
      cmd.offs_calc  = (state_ff == ST_CORN);
      cmd.commit     = (state_ff == ST_NEXT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         have_prev_ff <= 1'b0;
         closes_ff <= 1'b0;
         closing_ff <= 1'b0;
         pend_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         pend_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  closes_ff <= in_closes;
                  closing_ff <= !have_prev_ff;
                  if (have_prev_ff) state_ff <= ST_EDGE;
                  else if (in_closes) state_ff <= ST_EDGE;
                  else state_ff <= ST_NEXT;
                  have_prev_ff <= 1'b1;
               end
            end
            ST_EDGE: state_ff <= ST_LEN;
            ST_LEN: begin
               if (sts.zero_len) state_ff <= ST_NEXT;
               else begin
                  state_ff <= ST_SQRT;
                  pend_ff <= 1'b1;
               end
            end
            ST_SQRT: begin
               if (sts.sqrt_done && !pend_ff) begin
                  state_ff <= ST_DIVF;
                  pend_ff <= 1'b1;
               end
            end
            ST_DIVF: begin
               if (sts.div_done && !pend_ff) begin
                  state_ff <= ST_DIVH;
                  pend_ff <= 1'b1;
               end
            end
            ST_DIVH: if (sts.div_done && !pend_ff) state_ff <= ST_CORN;
            ST_CORN: begin
               k_ff <= '0;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_ready) begin
                  k_ff <= k_ff + 3'd1;
                  if (k_ff == 3'd5) state_ff <= ST_NEXT;
               end
            end
            ST_NEXT: begin
               if (!closing_ff && closes_ff) begin
                  closing_ff <= 1'b1;
                  state_ff <= ST_EDGE;
               end else begin
                  if (closes_ff) have_prev_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // a closing edge follows when the vertex carried the mark
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEXT && !closing_ff && closes_ff) |=> (state_ff == ST_EDGE))
      else $error("closing edge not started");
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !in_ready)
      else $error("input taken while emitting");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_ready && out_last) |=> (state_ff == ST_NEXT))
      else $error("bad end of run");

endmodule

// File: sv/polygon_outline_quad_expander_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_outline_quad_expander_unit
// expands closed polygon edges into thick quads, six vertices per edge
// ----------------------------------------------------------------------------
// channel  dir  bus
// req      in   tdata {vert_y, vert_x}, tlast closes_polygon
// rsp      out  tdata {out_y, out_x}, tlast run_end
// csr      in   apb, thickness at 0x0
// one vertex at a time: an edge runs the bit-serial square root, two passes of
// the serial divider, six transfers and four single steps; a zero-length edge
// skips the root, the divides and the transfers
// a marked vertex runs the closing edge after it
// output stalls hold the sequencer; synchronous reset, thickness 1.0
// ----------------------------------------------------------------------------
module polygon_outline_quad_expander_unit
   import poqe_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [2*COORD_WIDTH-1:0]      req_tdata,   // vert_x, vert_y
   input  logic                          req_tlast,   // closes_polygon
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [2*COORD_WIDTH-1:0]      rsp_tdata,   // out_x, out_y
   output logic                          rsp_tlast,   // run_end
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   logic [THICK_WIDTH-1:0] thick_ff;
   poqe_cmd_type cmd;
   poqe_sts_type sts;
   logic [2:0] sel;
   logic signed [COORD_WIDTH-1:0] pt_x, pt_y;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_THICKNESS) ? 32'(thick_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) thick_ff <= THICK_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_THICKNESS)
         thick_ff <= csr_pwdata[THICK_WIDTH-1:0];
   end

   poqe_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_closes(req_tlast),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_last(rsp_tlast),
      .sel(sel), .cmd(cmd), .sts(sts)
   );

   poqe_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .in_x(req_tdata[COORD_WIDTH-1:0]), .in_y(req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .thickness(thick_ff), .sel(sel), .pt_x(pt_x), .pt_y(pt_y)
   );

   assign rsp_tdata = {pt_y, pt_x};

endmodule
